// ===== src/fibonacci_mod_prime_matrix_power_top_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef FIBONACCI_MOD_PRIME_MATRIX_POWER_TOP_MACROS_SVH
`define FIBONACCI_MOD_PRIME_MATRIX_POWER_TOP_MACROS_SVH

// Same-cycle implication
`define FMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fmp_pkg.sv =====
`timescale 1ns / 1ps
package fmp_pkg;

  localparam int unsigned LEN_W        = 62;
  localparam int unsigned ELEM_W       = 30;
  localparam int unsigned EXP_BITS_DEF = 64;

  // Prime modulus and its Barrett factor floor(2^60 / p)
  localparam logic [ELEM_W-1:0] FIB_MOD = 30'd1000000007;
  localparam logic [30:0]       BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  // Product tags, one per multiply of a squaring step
  typedef logic [1:0] tag_t;
  localparam tag_t TAG_AA  = 2'd0;
  localparam tag_t TAG_BB  = 2'd1;
  localparam tag_t TAG_DD  = 2'd2;
  localparam tag_t TAG_BAD = 2'd3;

  typedef struct packed {
    logic              valid;
    tag_t              tag;
    logic [ELEM_W-1:0] opa;
    logic [ELEM_W-1:0] opb;
  } mm_req_t;

  typedef struct packed {
    logic              valid;
    tag_t              tag;
    logic [ELEM_W-1:0] value;
  } mm_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [ELEM_W-1:0] value;
  } seq_done_t;

  // Modular add of two reduced residues
  function automatic logic [ELEM_W-1:0] add_mod(input logic [ELEM_W-1:0] x,
                                                input logic [ELEM_W-1:0] y);
    logic [ELEM_W:0] s;
    logic [ELEM_W:0] t;
    s = {1'b0, x} + {1'b0, y};
    t = s - {1'b0, FIB_MOD};
    add_mod = (s >= {1'b0, FIB_MOD}) ? t[ELEM_W-1:0] : s[ELEM_W-1:0];
  endfunction

endpackage

// ===== src/fmp_mulmod.sv =====
`timescale 1ns / 1ps
module fmp_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  fmp_pkg::mm_req_t req,
  output fmp_pkg::mm_rsp_t rsp
);
  import fmp_pkg::*;

  logic [59:0] prod_r;
  logic [31:0] x2_r;
  logic [61:0] q2_r;
  logic [31:0] x3_r;
  logic [31:0] qp_r;
  logic [31:0] rem_r;
  logic [31:0] rem_p;
  logic [31:0] rem_2p;
  logic [ELEM_W-1:0] red_nxt;
  logic [3:0]  v_r;
  tag_t        tag1_r, tag2_r, tag3_r, tag4_r;
  mm_rsp_t     rsp_r;

  // Pick the remainder below p; Barrett leaves it below 3p
  always_comb begin
    rem_p  = rem_r - {2'b00, FIB_MOD};
    rem_2p = rem_r - {1'b0, FIB_MOD, 1'b0};
    if (rem_r >= {1'b0, FIB_MOD, 1'b0}) begin
      red_nxt = rem_2p[ELEM_W-1:0];
    end else if (rem_r >= {2'b00, FIB_MOD}) begin
      red_nxt = rem_p[ELEM_W-1:0];
    end else begin
      red_nxt = rem_r[ELEM_W-1:0];
    end
  end

  // Advance the valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      rsp_r.valid <= 1'b0;
    end else begin
      v_r         <= {v_r[2:0], req.valid};
      rsp_r.valid <= v_r[3];
    end
  end

  // Product, quotient estimate, quotient times p, difference, correction
  always_ff @(posedge clk) begin
    tag1_r      <= req.tag;
    prod_r      <= {30'd0, req.opa} * {30'd0, req.opb};
    tag2_r      <= tag1_r;
    x2_r        <= prod_r[31:0];
    q2_r        <= {31'd0, prod_r[59:29]} * {31'd0, BARRETT_MU};
    tag3_r      <= tag2_r;
    x3_r        <= x2_r;
    qp_r        <= 32'({31'd0, q2_r[61:31]} * {32'd0, FIB_MOD});
    tag4_r      <= tag3_r;
    rem_r       <= x3_r - qp_r;
    rsp_r.tag   <= tag4_r;
    rsp_r.value <= red_nxt;
  end

  assign rsp = rsp_r;

endmodule

// ===== src/fmp_seq.sv =====
`timescale 1ns / 1ps
module fmp_seq #(
  parameter int unsigned EXP_BITS = fmp_pkg::EXP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [EXP_BITS-1:0] exp_i,
  output logic               ready,
  output fmp_pkg::seq_done_t done,
  input  logic               ack,
  output fmp_pkg::mm_req_t   req,
  input  fmp_pkg::mm_rsp_t   rsp
);
  import fmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(EXP_BITS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_ISSUE = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_COMB  = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ELEM_W-1:0]   a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic [ELEM_W-1:0]   apd_r, apd_nxt;
  tag_t                iss_r, iss_nxt;
  logic [ELEM_W-1:0]   paa_r, pbb_r, pdd_r, pbad_r;
  mm_req_t             req_r, req_nxt;

  // The running power stays symmetric, so [[a,b],[b,d]] is held as a, b, d
  always_comb begin
    state_nxt   = state_r;
    exp_nxt     = exp_r;
    cnt_nxt     = cnt_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    d_nxt       = d_r;
    apd_nxt     = apd_r;
    iss_nxt     = iss_r;
    req_nxt     = req_r;
    req_nxt.valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          exp_nxt   = exp_i;
          cnt_nxt   = CNT_W'(EXP_BITS - 1);
          a_nxt     = ELEM_W'(1);
          b_nxt     = '0;
          d_nxt     = ELEM_W'(1);
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        apd_nxt   = add_mod(a_r, d_r);
        iss_nxt   = TAG_AA;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        req_nxt.valid = 1'b1;
        req_nxt.tag   = iss_r;
        case (iss_r)
          TAG_AA: begin
            req_nxt.opa = a_r;
            req_nxt.opb = a_r;
          end
          TAG_BB: begin
            req_nxt.opa = b_r;
            req_nxt.opb = b_r;
          end
          TAG_DD: begin
            req_nxt.opa = d_r;
            req_nxt.opb = d_r;
          end
          default: begin
            req_nxt.opa = b_r;
            req_nxt.opb = apd_r;
          end
        endcase
        iss_nxt = iss_r + tag_t'(1);
        if (iss_r == TAG_BAD) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rsp.valid && rsp.tag == TAG_BAD) begin
          state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        a_nxt     = add_mod(paa_r, pbb_r);
        d_nxt     = add_mod(pbb_r, pdd_r);
        b_nxt     = pbad_r;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // Multiply by the base matrix when this exponent bit is set
        if (exp_r[cnt_r]) begin
          a_nxt = add_mod(a_r, b_r);
          b_nxt = a_r;
          d_nxt = b_r;
        end
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_PREP;
        end
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r.valid <= req_nxt.valid;
    end
  end

  // Hold datapath state
  always_ff @(posedge clk) begin
    exp_r     <= exp_nxt;
    cnt_r     <= cnt_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    d_r       <= d_nxt;
    apd_r     <= apd_nxt;
    iss_r     <= iss_nxt;
    req_r.tag <= req_nxt.tag;
    req_r.opa <= req_nxt.opa;
    req_r.opb <= req_nxt.opb;
  end

  // Capture returning products by tag
  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      case (rsp.tag)
        TAG_AA:  paa_r  <= rsp.value;
        TAG_BB:  pbb_r  <= rsp.value;
        TAG_DD:  pdd_r  <= rsp.value;
        default: pbad_r <= rsp.value;
      endcase
    end
  end

  assign req        = req_r;
  assign ready      = (state_r == S_IDLE);
  assign done.valid = (state_r == S_DONE);
  assign done.value = b_r;

endmodule

// ===== src/fibonacci_mod_prime_matrix_power_top.sv =====
`timescale 1ns / 1ps
// Counts binary strings of length n with no two adjacent zeros: F(n+2) mod 1000000007.
// Input channel: in_valid / in_stall with in_string_length (62 bits, n).
// Result channel: out_valid / out_stall with out_count_mod (30 bits).
// A transaction is taken when valid is high and stall is low at a rising edge.
// The exponent n+2 is cut to its low EXP_BITS bits and walked from the top bit
// down; each bit squares the running matrix and, for a one bit, multiplies it
// by the Fibonacci base matrix (additions only).
// Each squaring issues four products into one pipelined Barrett multiplier
// with five register stages. One transaction is in work at a time; in_stall is
// high while it runs.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished result waits in the sequencer until that register is free,
// so a new input may be taken while the previous result still waits.
// rst_n is synchronous and active low; it empties the multiplier and the
// output register and returns the sequencer to idle.
module fibonacci_mod_prime_matrix_power_top #(
  parameter int unsigned EXP_BITS = fmp_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fmp_pkg::LEN_W-1:0]   in_string_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fmp_pkg::ELEM_W-1:0]  out_count_mod
);
  import fmp_pkg::*;

  `include "fibonacci_mod_prime_matrix_power_top_macros.svh"

  logic                start;
  logic [63:0]         exp_full;
  logic                seq_ready;
  logic                ack;
  seq_done_t           done;
  mm_req_t             mm_req;
  mm_rsp_t             mm_rsp;
  logic                out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0]   out_count_r;

  // Form the exponent n+2
  assign exp_full = {2'b00, in_string_length} + 64'd2;
  assign start    = in_valid && seq_ready;
  assign in_stall = !seq_ready;

  fmp_seq #(
    .EXP_BITS (EXP_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .exp_i (exp_full[EXP_BITS-1:0]),
    .ready (seq_ready),
    .done  (done),
    .ack   (ack),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  fmp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // Load the output register whenever it is empty or draining
  assign ack           = !out_valid_r || !out_stall;
  assign out_valid_nxt = ack ? done.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ack && done.valid) begin
      out_count_r <= done.value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_count_mod = out_count_r;

  `FMP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `FMP_ASSERT_NOW(a_rsp_while_busy, mm_rsp.valid, !seq_ready, "product returned while idle")
  `FMP_ASSERT_NOW(a_result_reduced, out_valid, out_count_mod < FIB_MOD, "result not reduced")

endmodule
